// ===== rtl/core/srbm_pkg.sv =====
// Shared types and constants for the sample ROM bank mapper.
// No dependencies; every other file in rtl/core imports this package.
package srbm_pkg;

	// Address map constants.
	localparam logic [24:0] ROM_BASE_OFFSET = 25'h0040000;
	localparam logic [17:0] TABLE_LIMIT     = 18'h00400;
	localparam int          BANK_BITS       = 16;  // one bank spans 0x10000 bytes
	localparam int          VALUE_W         = 8;
	localparam int          MOD_STEPS       = VALUE_W;

	// Request actions.
	localparam logic ACT_WRITE     = 1'b0;
	localparam logic ACT_TRANSLATE = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PAGE_ENABLE = 2'd0;
	localparam logic [1:0] CFG_ROM_BANKS0  = 2'd1;
	localparam logic [1:0] CFG_ROM_BANKS1  = 2'd2;

	// Input request.
	typedef struct packed {
		logic        action;
		logic [2:0]  bank_slot;
		logic [7:0]  bank_value;
		logic        chip_select;
		logic [17:0] sample_address;
	} req_t;

	// Output result.
	typedef struct packed {
		logic [24:0] rom_address;
		logic        address_valid;
	} rsp_t;

	// Command into the shared modulo unit.
	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [VALUE_W-1:0] divisor;
	} mod_cmd_t;

	// Status out of the shared modulo unit.
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [VALUE_W-1:0] remainder;
	} mod_sts_t;

endpackage

// ===== rtl/core/srbm_mod_unit.sv =====
// Iterative restoring modulo unit: one remainder bit per cycle.
// Depends on srbm_pkg for the command and status structs.
module srbm_mod_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  srbm_pkg::mod_cmd_t cmd,
	output srbm_pkg::mod_sts_t sts
);
	import srbm_pkg::*;

	logic [VALUE_W-1:0] dvd_q;
	logic [VALUE_W-1:0] dsr_q;
	logic [VALUE_W-1:0] rem_q;
	logic [$clog2(MOD_STEPS)-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [VALUE_W:0]   trial;
	logic [VALUE_W:0]   diff;
	logic [VALUE_W-1:0] rem_next;
	logic               last_step;

	// One shift-and-subtract step on the partial remainder.
	always_comb begin
		trial = {rem_q, dvd_q[VALUE_W-1]};
		diff  = trial - {1'b0, dsr_q};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = diff[VALUE_W-1:0];
		end else begin
			rem_next = trial[VALUE_W-1:0];
		end
	end

	// The final step of the loop is running this cycle.
	assign last_step = !cmd.start && busy_q
		&& (cnt_q == ($clog2(MOD_STEPS))'(MOD_STEPS - 1));

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dsr_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign sts.busy      = busy_q;
	assign sts.done      = done_q;
	assign sts.remainder = rem_q;

endmodule

// ===== rtl/core/srbm_bank_regs.sv =====
// Eight 8-bit bank registers, four per chip, with one write and one read port.
// Depends on srbm_pkg for the value width.
module srbm_bank_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [2:0]                  widx,
	input  logic [srbm_pkg::VALUE_W-1:0] wdata,
	input  logic [2:0]                  ridx,
	output logic [srbm_pkg::VALUE_W-1:0] rdata
);
	import srbm_pkg::*;

	logic [VALUE_W-1:0] bank_q [8];

	// Register file write; reset clears every bank to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				bank_q[i] <= '0;
			end
		end else if (we) begin
			bank_q[widx] <= wdata;
		end
	end

	// Read port used by the translation path.
	assign rdata = bank_q[ridx];

endmodule

// ===== rtl/core/sample_rom_bank_mapper_top.sv =====
// Sample ROM bank mapper: bank registers plus address translation.
// A write request gives its result from the output register once accepted; a translate
// request passes through a load step, the 8 modulo steps of the shared unit and the
// output register; an absent ROM answers from the output register, skipping the unit.
// Throughput: one request at a time; the 8-step modulo loop and a stalled output hold new requests.
// Reset (arst_n low): bank registers zero, page_enable 3, ROM sizes 0, no result.
module sample_rom_bank_mapper_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srbm_pkg::req_t       in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srbm_pkg::rsp_t       out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_wdata
);
	import srbm_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic               state_q;
	logic [1:0]         page_enable_q;
	logic [7:0]         rom_banks0_q;
	logic [7:0]         rom_banks1_q;
	logic [15:0]        offset_q;
	logic               out_valid_q;
	rsp_t               out_data_q;

	logic               accept;
	logic               is_write;
	logic [7:0]         banks_sel;
	logic               paged;
	logic               low_table;
	logic [1:0]         bank_idx;
	logic [2:0]         rd_idx;
	logic [VALUE_W-1:0] bank_val;
	mod_cmd_t           mod_cmd;
	mod_sts_t           mod_sts;
	logic [24:0]        phys;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_enable_q <= 2'b11;
			rom_banks0_q  <= '0;
			rom_banks1_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGE_ENABLE: page_enable_q <= cfg_wdata[1:0];
				CFG_ROM_BANKS0:  rom_banks0_q  <= cfg_wdata;
				CFG_ROM_BANKS1:  rom_banks1_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Request decode: pick the bank register and the ROM size.
	always_comb begin
		accept    = in_valid && in_ready;
		is_write  = (in_data.action == ACT_WRITE);
		banks_sel = in_data.chip_select ? rom_banks1_q : rom_banks0_q;
		paged     = page_enable_q[in_data.chip_select];
		low_table = paged && (in_data.sample_address < TABLE_LIMIT);
		bank_idx  = low_table ? in_data.sample_address[9:8] : in_data.sample_address[17:16];
		rd_idx    = {in_data.chip_select, bank_idx};
	end

	srbm_bank_regs u_bank_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (accept && is_write),
		.widx   (in_data.bank_slot),
		.wdata  (in_data.bank_value),
		.ridx   (rd_idx),
		.rdata  (bank_val)
	);

	// Start the modulo unit on a translate request with a present ROM.
	always_comb begin
		mod_cmd.start    = accept && (in_data.action == ACT_TRANSLATE) && (banks_sel != '0);
		mod_cmd.dividend = bank_val;
		mod_cmd.divisor  = banks_sel;
	end

	srbm_mod_unit u_mod_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mod_cmd),
		.sts    (mod_sts)
	);

	// Physical address: base plus reduced bank times bank size plus offset.
	assign phys = ROM_BASE_OFFSET + {1'b0, mod_sts.remainder, {BANK_BITS{1'b0}}}
		+ {9'b0, offset_q};

	// Sequencer: idle until a translation starts, then wait for the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (mod_cmd.start) state_q <= ST_CALC;
				ST_CALC: if (mod_sts.done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Offset within the bank is held for the whole translation.
	always_ff @(posedge clk) begin
		if (mod_cmd.start) begin
			offset_q <= in_data.sample_address[BANK_BITS-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !mod_cmd.start) begin
			out_valid_q <= 1'b1;
		end else if (state_q == ST_CALC && mod_sts.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !mod_cmd.start) begin
			out_data_q <= '0;
		end else if (state_q == ST_CALC && mod_sts.done) begin
			out_data_q.rom_address   <= phys;
			out_data_q.address_valid <= 1'b1;
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The modulo unit only finishes while a translation is pending.
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		mod_sts.done |-> state_q == ST_CALC)
		else $error("modulo unit finished outside a translation");

	// No new request is taken while the modulo unit iterates.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mod_sts.busy |-> !in_ready)
		else $error("request accepted while modulo unit busy");

	// A translation with a present ROM enters the calculation state.
	a_start_calc: assert property (@(posedge clk) disable iff (!arst_n)
		mod_cmd.start |=> state_q == ST_CALC && mod_sts.busy)
		else $error("translation did not start the modulo unit");

	// A valid translation always lands at or above the ROM base.
	a_valid_base: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.address_valid) |-> out_data.rom_address >= ROM_BASE_OFFSET)
		else $error("translated address below ROM base");

endmodule
